// ===== sv/eabf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eabf_pkg
// Shared types and constants of the event admission boost filter.
// ----------------------------------------------------------------------------
package eabf_pkg;

    localparam int unsigned DEF_TABLE_ENTRIES = 96;
    localparam int unsigned DEF_WINDOW_MS     = 60000;

    localparam int unsigned TIME_W = 48;
    localparam int unsigned ID_W   = 32;
    localparam int unsigned CNT_W  = 17;
    localparam int unsigned TOT_W  = 32;
    localparam int unsigned CFG_W  = 17;
    localparam int unsigned CIDX_W = 3;

    localparam logic [CIDX_W-1:0] CFG_ENABLED        = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_BOOST_SECONDS  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SEV_FLOOR      = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_ADMIT_BUDGET   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_SCRIPT_BUDGET  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_KEEP_ALL_NET   = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_KEEP_LIFECYCLE = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_KEEP_AUTH      = 3'd7;

    localparam logic [3:0] CLS_PS_SCRIPT  = 4'd1;
    localparam logic [3:0] CLS_WMI_SCRIPT = 4'd2;
    localparam logic [3:0] CLS_SHELLCODE  = 4'd3;
    localparam logic [3:0] CLS_ALERT      = 4'd5;
    localparam logic [3:0] CLS_CONNECT    = 4'd6;
    localparam logic [3:0] CLS_TLS        = 4'd9;
    localparam logic [3:0] CLS_FILE       = 4'd10;
    localparam logic [3:0] CLS_REGISTRY   = 4'd11;
    localparam logic [3:0] CLS_LIFECYCLE  = 4'd12;
    localparam logic [3:0] CLS_AUTH       = 4'd13;

    localparam logic FUNC_RAISE = 1'b0;

    typedef struct packed {
        logic             enabled;
        logic [10:0]      boost_seconds;
        logic [2:0]       sev_floor;
        logic [CNT_W-1:0] admit_budget;
        logic [CNT_W-1:0] script_budget;
        logic             keep_all_net;
        logic             keep_lifecycle;
        logic             keep_auth;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic              vld;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dl;
    } t_tbl_wr;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ADD, ST_RAISE, ST_SCAN, ST_WIN, ST_COUNT, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        STEP_MARK_P, STEP_MARK_PP, STEP_LOOK_P, STEP_LOOK_PP, STEP_REMARK
    } t_step;

endpackage
`default_nettype wire

// ===== sv/eabf_tbl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eabf_tbl
// Boosted id table: one write port, one registered read port, valid flags.
// ----------------------------------------------------------------------------
module eabf_tbl
    import eabf_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int unsigned AW = $clog2(TABLE_ENTRIES)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [AW-1:0]     i_rd_addr,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire t_tbl_wr           i_wr,
    output logic                   o_rd_vld,
    output logic [ID_W-1:0]        o_rd_id,
    output logic [TIME_W-1:0]      o_rd_dl
);

    logic [ID_W-1:0]      r_mem_id [TABLE_ENTRIES];
    logic [TIME_W-1:0]    r_mem_dl [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_id[i_wr_addr] <= i_wr.id;
            r_mem_dl[i_wr_addr] <= i_wr.dl;
        end
        o_rd_id <= r_mem_id[i_rd_addr];
        o_rd_dl <= r_mem_dl[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            o_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr_addr] <= i_wr.vld;
            end
            o_rd_vld <= r_vld[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/eabf_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eabf_seq
// Item sequencer: boost state, table scans, window budget and result word.
// ----------------------------------------------------------------------------
module eabf_seq
    import eabf_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int unsigned WINDOW_MS     = DEF_WINDOW_MS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_func,
    input  wire logic [TIME_W-1:0] i_now_ms,
    input  wire logic [3:0]        i_severity,
    input  wire logic [ID_W-1:0]   i_proc_id,
    input  wire logic [ID_W-1:0]   i_parent_id,
    input  wire logic [3:0]        i_event_class,
    input  wire logic              i_name_interesting,
    input  wire logic [15:0]       i_remote_port,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_admit,
    output logic                   o_boost_active,
    output logic [3:0]             o_boost_level,
    output logic [TOT_W-1:0]       o_boost_total
);

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] LP_LAST_ISS = CW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LP_LAST_PTR = AW'(TABLE_ENTRIES - 1);
    localparam logic [TIME_W-1:0] LP_WIN = TIME_W'(WINDOW_MS);

    t_state r_state, n_state;
    t_step  r_step;

    logic              r_func, r_name, r_hit, r_admit;
    logic [TIME_W-1:0] r_now, r_until, r_kdl;
    logic [3:0]        r_sev, r_cls;
    logic [ID_W-1:0]   r_pid, r_ppid, r_key;
    logic [15:0]       r_port;
    logic [20:0]       r_prod;
    logic [CW-1:0]     r_iss;
    logic              r_chk;
    logic [AW-1:0]     r_chk_addr, r_ptr;

    logic [TIME_W-1:0] r_boost_dl, r_win_start;
    logic [3:0]        r_level;
    logic [TOT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_win_used, r_scr_used;

    logic              rd_vld;
    logic [ID_W-1:0]   rd_id;
    logic [TIME_W-1:0] rd_dl;
    t_tbl_wr           tbl_wr;
    logic [AW-1:0]     tbl_wr_addr;

    logic accept, match, scan_done, live, is_look, remark_ok, raise_ok, query_ok;
    logic elig, is_net, is_alert, is_script, admin_port, decide;
    logic [AW-1:0]     ptr_nxt;
    logic [TIME_W:0]   until_sum;
    logic [TIME_W-1:0] win_age;
    logic              win_restart;
    logic [CNT_W-1:0]  scr_new, win_new;

    eabf_tbl #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .AW           (AW)
    ) u_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_addr(r_iss[AW-1:0]),
        .i_wr_addr(tbl_wr_addr),
        .i_wr     (tbl_wr),
        .o_rd_vld (rd_vld),
        .o_rd_id  (rd_id),
        .o_rd_dl  (rd_dl)
    );

    assign accept    = i_in_valid && !o_in_stall;
    assign raise_ok  = i_cfg.enabled && (i_severity >= {1'b0, i_cfg.sev_floor});
    assign query_ok  = i_cfg.enabled && (i_now_ms <= r_boost_dl);
    assign match     = r_chk && rd_vld && (rd_id == r_key);
    assign scan_done = (r_key == '0) || match || (!r_chk && (r_iss == LP_LAST_ISS));
    assign live      = match && (r_now <= rd_dl);
    assign is_look   = (r_step == STEP_LOOK_P) || (r_step == STEP_LOOK_PP);
    assign remark_ok = (r_pid != '0) && (r_ppid != '0);
    assign ptr_nxt   = (r_ptr == LP_LAST_PTR) ? '0 : r_ptr + 1'b1;
    assign until_sum = {1'b0, r_now} + {{(TIME_W-20){1'b0}}, r_prod};

    assign is_net    = (r_cls >= CLS_CONNECT) && (r_cls <= CLS_TLS);
    assign is_alert  = (r_cls >= CLS_SHELLCODE) && (r_cls <= CLS_ALERT);
    assign is_script = (r_cls == CLS_PS_SCRIPT) || (r_cls == CLS_WMI_SCRIPT);
    assign elig      = r_hit || is_net || is_alert;
    assign admin_port = (r_port == 16'd22) || (r_port == 16'd135) || (r_port == 16'd139) ||
                        (r_port == 16'd445) || (r_port == 16'd3389) ||
                        (r_port == 16'd5985) || (r_port == 16'd5986) ||
                        (r_port == 16'd47001);
    assign win_age     = r_now - r_win_start;
    assign win_restart = (r_win_start == '0) || (r_now < r_win_start) || (win_age >= LP_WIN);
    assign scr_new = (r_scr_used == '1) ? r_scr_used : r_scr_used + 1'b1;
    assign win_new = (r_win_used == '1) ? r_win_used : r_win_used + 1'b1;

    always_comb begin
        priority if (r_cls <= CLS_ALERT) begin
            decide = 1'b1;
        end else if (is_net) begin
            decide = r_hit || r_name || admin_port || i_cfg.keep_all_net;
        end else if ((r_cls == CLS_FILE) || (r_cls == CLS_REGISTRY)) begin
            decide = r_hit;
        end else if (r_cls == CLS_LIFECYCLE) begin
            decide = r_hit && i_cfg.keep_lifecycle;
        end else if (r_cls == CLS_AUTH) begin
            decide = i_cfg.keep_auth;
        end else begin
            decide = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_RAISE) begin
                        n_state = raise_ok ? ST_MUL : ST_DONE;
                    end else begin
                        n_state = query_ok ? ST_SCAN : ST_DONE;
                    end
                end
            end
            ST_MUL:   n_state = ST_ADD;
            ST_ADD:   n_state = ST_RAISE;
            ST_RAISE: n_state = ST_SCAN;
            ST_SCAN: begin
                if (scan_done) begin
                    unique case (r_step)
                        STEP_MARK_P:  n_state = ST_SCAN;
                        STEP_MARK_PP: n_state = ST_DONE;
                        STEP_LOOK_P:  n_state = (live && !remark_ok) ? ST_WIN : ST_SCAN;
                        STEP_LOOK_PP: n_state = (live && remark_ok) ? ST_SCAN : ST_WIN;
                        STEP_REMARK:  n_state = ST_WIN;
                        default:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_WIN: begin
                if (!elig || (i_cfg.admit_budget == '0)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: n_state = ST_DONE;
            ST_DONE: begin
                if (!o_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs: handshake and table write
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        tbl_wr      = '0;
        tbl_wr_addr = r_chk_addr;
        if ((r_state == ST_SCAN) && scan_done && (r_key != '0)) begin
            tbl_wr.id = r_key;
            tbl_wr.dl = r_kdl;
            if (match) begin
                tbl_wr.en  = !is_look || !live;
                tbl_wr.vld = !is_look;
            end else if (!is_look) begin
                tbl_wr.en   = 1'b1;
                tbl_wr.vld  = 1'b1;
                tbl_wr_addr = ptr_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_MARK_P;
            r_ptr       <= '0;
            r_boost_dl  <= '0;
            r_level     <= '0;
            r_count     <= '0;
            r_win_start <= '0;
            r_win_used  <= '0;
            r_scr_used  <= '0;
            r_chk       <= 1'b0;
            r_iss       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_DONE) && (!o_out_valid || !i_out_stall)) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_func  <= i_func;
                        r_now   <= i_now_ms;
                        r_sev   <= i_severity;
                        r_pid   <= i_proc_id;
                        r_ppid  <= i_parent_id;
                        r_cls   <= i_event_class;
                        r_name  <= i_name_interesting;
                        r_port  <= i_remote_port;
                        r_hit   <= 1'b0;
                        r_admit <= 1'b0;
                        r_step  <= STEP_LOOK_P;
                        r_key   <= i_proc_id;
                        r_iss   <= '0;
                        r_chk   <= 1'b0;
                    end
                end
                ST_MUL: r_prod <= 21'(i_cfg.boost_seconds * 10'd1000);
                ST_ADD: r_until <= until_sum[TIME_W] ? '1 : until_sum[TIME_W-1:0];
                ST_RAISE: begin
                    if (r_until > r_boost_dl) begin
                        r_boost_dl <= r_until;
                    end
                    if (r_sev > r_level) begin
                        r_level <= r_sev;
                    end
                    if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_step <= STEP_MARK_P;
                    r_key  <= r_pid;
                    r_kdl  <= r_until;
                    r_iss  <= '0;
                    r_chk  <= 1'b0;
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        r_iss <= '0;
                        r_chk <= 1'b0;
                        if (tbl_wr.en && tbl_wr.vld && !match) begin
                            r_ptr <= ptr_nxt;
                        end
                        if (is_look) begin
                            r_hit <= live;
                        end
                        unique case (r_step)
                            STEP_MARK_P: begin
                                r_step <= STEP_MARK_PP;
                                r_key  <= r_ppid;
                            end
                            STEP_LOOK_P: begin
                                if (live) begin
                                    r_step <= STEP_REMARK;
                                    r_key  <= r_pid;
                                    r_kdl  <= r_boost_dl;
                                end else begin
                                    r_step <= STEP_LOOK_PP;
                                    r_key  <= r_ppid;
                                end
                            end
                            STEP_LOOK_PP: begin
                                r_step <= STEP_REMARK;
                                r_key  <= r_pid;
                                r_kdl  <= r_boost_dl;
                            end
                            default: begin
                                r_step <= r_step;
                            end
                        endcase
                    end else begin
                        r_chk      <= (r_iss != LP_LAST_ISS);
                        r_chk_addr <= r_iss[AW-1:0];
                        if (r_iss != LP_LAST_ISS) begin
                            r_iss <= r_iss + 1'b1;
                        end
                    end
                end
                ST_WIN: begin
                    if (elig && (i_cfg.admit_budget == '0)) begin
                        r_admit <= decide;
                    end else if (elig && win_restart) begin
                        r_win_start <= r_now;
                        r_win_used  <= '0;
                        r_scr_used  <= '0;
                    end
                end
                ST_COUNT: begin
                    if (is_script && (i_cfg.script_budget != '0)) begin
                        r_scr_used <= scr_new;
                    end
                    if (is_script && (i_cfg.script_budget != '0) &&
                        (scr_new > i_cfg.script_budget)) begin
                        r_admit <= 1'b0;
                    end else begin
                        r_win_used <= win_new;
                        r_admit    <= (win_new <= i_cfg.admit_budget) && decide;
                    end
                end
                ST_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_admit        <= r_admit;
                        o_boost_active <= i_cfg.enabled && (r_now <= r_boost_dl);
                        o_boost_level  <= r_level;
                        o_boost_total  <= r_count;
                    end
                end
                default: begin
                    r_chk <= 1'b0;
                end
            endcase
        end
    end

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result word loaded outside completion");

    a_tbl_wr_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_wr.en |-> (r_state == ST_SCAN) && scan_done)
        else $error("table written outside a finishing scan");

    a_look_on_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && is_look) |-> (r_func != FUNC_RAISE))
        else $error("lookup scan on a raise word");

    a_total_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("raise count went down");

endmodule
`default_nettype wire

// ===== sv/event_admission_boost_filter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// event_admission_boost_filter_unit
// Boost window and admission filter for timestamped security events.
// ----------------------------------------------------------------------------
// One word is processed at a time and gives one result word. Each id search
// sweeps the id table through its single read port, one entry per cycle, and
// a query may search the process id, the parent id and then refresh the
// process id. Words that are filtered out before the table go straight to
// the result. The next word is taken in the cycle after the result is
// loaded. The result sits in an output register, so the next word is taken
// while the previous result waits.
module event_admission_boost_filter_unit
    import eabf_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int unsigned WINDOW_MS     = DEF_WINDOW_MS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CIDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_func,
    input  wire logic [TIME_W-1:0] i_now_ms,
    input  wire logic [3:0]        i_severity,
    input  wire logic [ID_W-1:0]   i_proc_id,
    input  wire logic [ID_W-1:0]   i_parent_id,
    input  wire logic [3:0]        i_event_class,
    input  wire logic              i_name_interesting,
    input  wire logic [15:0]       i_remote_port,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_admit,
    output logic                   o_boost_active,
    output logic [3:0]             o_boost_level,
    output logic [TOT_W-1:0]       o_boost_total
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled        <= 1'b1;
            r_cfg.boost_seconds  <= 11'd180;
            r_cfg.sev_floor      <= 3'd3;
            r_cfg.admit_budget   <= 17'd1200;
            r_cfg.script_budget  <= 17'd240;
            r_cfg.keep_all_net   <= 1'b0;
            r_cfg.keep_lifecycle <= 1'b0;
            r_cfg.keep_auth      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ENABLED:        r_cfg.enabled        <= i_cfg_data[0];
                CFG_BOOST_SECONDS:  r_cfg.boost_seconds  <= i_cfg_data[10:0];
                CFG_SEV_FLOOR:      r_cfg.sev_floor      <= i_cfg_data[2:0];
                CFG_ADMIT_BUDGET:   r_cfg.admit_budget   <= i_cfg_data;
                CFG_SCRIPT_BUDGET:  r_cfg.script_budget  <= i_cfg_data;
                CFG_KEEP_ALL_NET:   r_cfg.keep_all_net   <= i_cfg_data[0];
                CFG_KEEP_LIFECYCLE: r_cfg.keep_lifecycle <= i_cfg_data[0];
                CFG_KEEP_AUTH:      r_cfg.keep_auth      <= i_cfg_data[0];
                default:            r_cfg.enabled        <= r_cfg.enabled;
            endcase
        end
    end

    eabf_seq #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .WINDOW_MS    (WINDOW_MS)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_now_ms          (i_now_ms),
        .i_severity        (i_severity),
        .i_proc_id         (i_proc_id),
        .i_parent_id       (i_parent_id),
        .i_event_class     (i_event_class),
        .i_name_interesting(i_name_interesting),
        .i_remote_port     (i_remote_port),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_admit           (o_admit),
        .o_boost_active    (o_boost_active),
        .o_boost_level     (o_boost_level),
        .o_boost_total     (o_boost_total)
    );

endmodule
`default_nettype wire

// ===== verif/event_admission_boost_filter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_admission_boost_filter_unit_tb
// Self-checking bench: raise and admission words go through the filter while
// a local model of the boost deadline, id table and window budget predicts
// every result word. The input idles and the result side stalls at random.
// ----------------------------------------------------------------------------
module event_admission_boost_filter_unit_tb;
    import eabf_pkg::*;

    localparam int unsigned N_IDS    = 96;
    localparam logic [47:0] WIN_MS   = 48'd60000;
    localparam logic [47:0] T48_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] C17_MAX  = 17'h1FFFF;
    localparam logic        FUNC_ADMIT = 1'b1;
    localparam logic [3:0]  CLS_PROC_CREATE = 4'd0;
    localparam logic [3:0]  CLS_DNS         = 4'd8;
    localparam logic [3:0]  CLS_OTHER       = 4'd14;
    localparam logic [3:0]  CLS_RESERVED    = 4'd15;

    typedef struct packed {
        logic        admit;
        logic        active;
        logic [3:0]  level;
        logic [31:0] total;
    } t_verdict;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_func;
    logic [TIME_W-1:0] i_now_ms;
    logic [3:0]        i_severity;
    logic [ID_W-1:0]   i_proc_id;
    logic [ID_W-1:0]   i_parent_id;
    logic [3:0]        i_event_class;
    logic              i_name_interesting;
    logic [15:0]       i_remote_port;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_admit;
    logic              o_boost_active;
    logic [3:0]        o_boost_level;
    logic [TOT_W-1:0]  o_boost_total;

    event_admission_boost_filter_unit uut (.*);

    // shadow configuration and filter state
    t_cfg        cfg_sh;
    logic [31:0] boosted_ids [N_IDS];
    logic [47:0] boosted_dl  [N_IDS];
    int unsigned slot_ptr;
    logic [47:0] boost_until;
    logic [3:0]  peak_level;
    logic [31:0] raise_total;
    logic [47:0] win_start;
    logic [16:0] win_used;
    logic [16:0] script_used;

    t_verdict    pending_verdicts[$];
    bit          failed;
    bit          calm;
    int          stall_left;
    logic [47:0] clock_ms;
    logic [31:0] id_pool [160];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(30, 80);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected word admit=%0d active=%0d level=%0d total=%0d",
                         $time, o_admit, o_boost_active, o_boost_level, o_boost_total);
                failed = 1'b1;
            end else begin
                exp_v = pending_verdicts.pop_front();
                if (o_admit !== exp_v.admit) begin
                    $display("%0t: admit expected %0d got %0d", $time, exp_v.admit, o_admit);
                    failed = 1'b1;
                end
                if (o_boost_active !== exp_v.active) begin
                    $display("%0t: boost_active expected %0d got %0d",
                             $time, exp_v.active, o_boost_active);
                    failed = 1'b1;
                end
                if (o_boost_level !== exp_v.level) begin
                    $display("%0t: boost_level expected %0d got %0d",
                             $time, exp_v.level, o_boost_level);
                    failed = 1'b1;
                end
                if (o_boost_total !== exp_v.total) begin
                    $display("%0t: boost_total expected %0d got %0d",
                             $time, exp_v.total, o_boost_total);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic void mark_boosted(logic [31:0] id, logic [47:0] expiry);
        if (id == 0) return;
        for (int k = 0; k < N_IDS; k++) begin
            if (boosted_ids[k] == id) begin
                boosted_dl[k] = expiry;
                return;
            end
        end
        slot_ptr = (slot_ptr + 1) % N_IDS;
        boosted_ids[slot_ptr] = id;
        boosted_dl[slot_ptr] = expiry;
    endfunction

    function automatic bit id_still_boosted(logic [31:0] id, logic [47:0] now_ms);
        if (id == 0) return 1'b0;
        for (int k = 0; k < N_IDS; k++) begin
            if (boosted_ids[k] == id) begin
                if (now_ms <= boosted_dl[k]) return 1'b1;
                boosted_ids[k] = '0;
                boosted_dl[k] = '0;
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit within_budget(logic [3:0] cls, logic [47:0] now_ms);
        if (cfg_sh.admit_budget == 0) return 1'b1;
        if (win_start == 0 || now_ms < win_start || now_ms - win_start >= WIN_MS) begin
            win_start = now_ms;
            win_used = '0;
            script_used = '0;
        end
        if ((cls == CLS_PS_SCRIPT || cls == CLS_WMI_SCRIPT) && cfg_sh.script_budget != 0) begin
            if (script_used < C17_MAX) script_used++;
            if (script_used > cfg_sh.script_budget) return 1'b0;
        end
        if (win_used < C17_MAX) win_used++;
        return win_used <= cfg_sh.admit_budget;
    endfunction

    function automatic bit admin_port(logic [15:0] p);
        return p == 16'd22 || p == 16'd135 || p == 16'd139 || p == 16'd445 ||
               p == 16'd3389 || p == 16'd5985 || p == 16'd5986 || p == 16'd47001;
    endfunction

    function automatic void predict_verdict(logic func, logic [47:0] now_ms, logic [3:0] sev,
                                            logic [31:0] pid, logic [31:0] ppid,
                                            logic [3:0] cls, logic name_hit,
                                            logic [15:0] port);
        t_verdict v;
        logic [48:0] until_w;
        logic [47:0] expiry;
        bit hit, net, alert, ok;
        v.admit = 1'b0;
        if (func == FUNC_RAISE) begin
            if (cfg_sh.enabled && sev >= {1'b0, cfg_sh.sev_floor}) begin
                until_w = {1'b0, now_ms} + 49'(cfg_sh.boost_seconds) * 49'd1000;
                expiry = (until_w > {1'b0, T48_MAX}) ? T48_MAX : until_w[47:0];
                if (expiry > boost_until) boost_until = expiry;
                if (sev > peak_level) peak_level = sev;
                mark_boosted(pid, expiry);
                mark_boosted(ppid, expiry);
                if (raise_total != 32'hFFFF_FFFF) raise_total++;
            end
        end else if (cfg_sh.enabled && now_ms <= boost_until) begin
            hit = id_still_boosted(pid, now_ms);
            net = cls >= CLS_CONNECT && cls <= CLS_TLS;
            alert = cls >= CLS_SHELLCODE && cls <= CLS_ALERT;
            if (!hit) hit = id_still_boosted(ppid, now_ms);
            if (hit && ppid != 0 && pid != 0) mark_boosted(pid, boost_until);
            if ((hit || net || alert) && within_budget(cls, now_ms)) begin
                if (cls <= CLS_ALERT) ok = 1'b1;
                else if (net) ok = hit || name_hit || admin_port(port) || cfg_sh.keep_all_net;
                else if (cls == CLS_FILE || cls == CLS_REGISTRY) ok = hit;
                else if (cls == CLS_LIFECYCLE) ok = hit && cfg_sh.keep_lifecycle;
                else if (cls == CLS_AUTH) ok = cfg_sh.keep_auth;
                else ok = 1'b0;
                v.admit = ok;
            end
        end
        v.active = cfg_sh.enabled && now_ms <= boost_until;
        v.level = peak_level;
        v.total = raise_total;
        pending_verdicts.push_back(v);
    endfunction

    task automatic send_word(logic func, logic [47:0] now_ms, logic [3:0] sev,
                             logic [31:0] pid, logic [31:0] ppid, logic [3:0] cls,
                             logic name_hit, logic [15:0] port);
        int g;
        i_in_valid <= 1'b1;
        i_func <= func;
        i_now_ms <= now_ms;
        i_severity <= sev;
        i_proc_id <= pid;
        i_parent_id <= ppid;
        i_event_class <= cls;
        i_name_interesting <= name_hit;
        i_remote_port <= port;
        do @(posedge i_clk); while (o_in_stall);
        predict_verdict(func, now_ms, sev, pid, ppid, cls, name_hit, port);
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // hold the write enable high across consecutive writes; the caller drops it
    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ENABLED:        cfg_sh.enabled = data[0];
            CFG_BOOST_SECONDS:  cfg_sh.boost_seconds = data[10:0];
            CFG_SEV_FLOOR:      cfg_sh.sev_floor = data[2:0];
            CFG_ADMIT_BUDGET:   cfg_sh.admit_budget = data;
            CFG_SCRIPT_BUDGET:  cfg_sh.script_budget = data;
            CFG_KEEP_ALL_NET:   cfg_sh.keep_all_net = data[0];
            CFG_KEEP_LIFECYCLE: cfg_sh.keep_lifecycle = data[0];
            default:            cfg_sh.keep_auth = data[0];
        endcase
    endtask

    function automatic logic [15:0] pick_port();
        logic [15:0] ports [8] = '{16'd22, 16'd135, 16'd139, 16'd445, 16'd3389,
                                   16'd5985, 16'd5986, 16'd47001};
        if ($urandom_range(0, 2) == 0) return ports[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 9) == 0) return '0;
        return id_pool[$urandom_range(0, 159)];
    endfunction

    task automatic send_random_word();
        logic [3:0] cls;
        if ($urandom_range(0, 4) == 0) begin
            send_word(1'($urandom), {16'($urandom), 32'($urandom)}, 4'($urandom),
                      $urandom, $urandom, 4'($urandom), 1'($urandom), 16'($urandom));
            return;
        end
        case ($urandom_range(0, 19))
            0:       clock_ms = clock_ms + $urandom_range(100000, 2000000);
            1:       clock_ms = (clock_ms > 5000) ? clock_ms - $urandom_range(1, 5000) : 0;
            default: clock_ms = clock_ms + $urandom_range(0, 3000);
        endcase
        cls = 4'($urandom);
        if ($urandom_range(0, 9) < 3)
            send_word(FUNC_RAISE, clock_ms, 4'($urandom), pick_id(), pick_id(), cls,
                      1'($urandom), pick_port());
        else
            send_word(FUNC_ADMIT, clock_ms, 4'($urandom), pick_id(), pick_id(), cls,
                      1'($urandom), pick_port());
    endtask

    task automatic test_directed();
        send_word(FUNC_ADMIT, 48'd0, 4'd0, 32'd5, 32'd0, CLS_SHELLCODE, 1'b0, 16'd0);
        send_word(FUNC_RAISE, 48'd1000, 4'd2, 32'd7, 32'd0, CLS_PROC_CREATE, 1'b0, 16'd0);
        send_word(FUNC_RAISE, 48'd1000, 4'd15, 32'd7, 32'd8, CLS_PROC_CREATE, 1'b0, 16'd0);
        send_word(FUNC_RAISE, 48'd2000, 4'd3, 32'd0, 32'd0, CLS_PROC_CREATE, 1'b0, 16'd0);
        for (int c = 0; c < 16; c++)
            send_word(FUNC_ADMIT, 48'd3000, 4'd0, (c % 2) ? 32'd0 : 32'd7,
                      (c % 2) ? 32'd8 : 32'd0, 4'(c), 1'b0, 16'd80);
        send_word(FUNC_ADMIT, 48'd3100, 4'd0, 32'd99, 32'd0, CLS_CONNECT, 1'b0, 16'd3389);
        send_word(FUNC_ADMIT, 48'd3100, 4'd0, 32'd99, 32'd0, CLS_DNS, 1'b1, 16'd53);
        send_word(FUNC_ADMIT, 48'd3100, 4'd0, 32'd99, 32'd0, CLS_TLS, 1'b0, 16'd47001);
        send_word(FUNC_RAISE, 48'd5000, 4'd4, 32'd40, 32'd0, CLS_OTHER, 1'b0, 16'd0);
        send_word(FUNC_RAISE, 48'd150000, 4'd4, 32'd41, 32'd0, CLS_OTHER, 1'b0, 16'd0);
        send_word(FUNC_ADMIT, 48'd186000, 4'd0, 32'd40, 32'd0, CLS_FILE, 1'b0, 16'd0);
        send_word(FUNC_ADMIT, 48'd186001, 4'd0, 32'd40, 32'd41, CLS_FILE, 1'b0, 16'd0);
        send_word(FUNC_RAISE, 48'hFFFF_FFFF_FF00, 4'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  CLS_RESERVED, 1'b1, 16'hFFFF);
        send_word(FUNC_ADMIT, 48'd10, 4'hF, 32'hFFFF_FFFF, 32'd0, CLS_ALERT, 1'b1, 16'hFFFF);
        drain();
    endtask

    task automatic test_config_phase(int n_words, bit extreme);
        logic [16:0] budgets [5] = '{17'd0, 17'd1, 17'd3, 17'd100000, 17'h1FFFF};
        write_reg(CFG_ENABLED, ($urandom_range(0, 4) == 0) ? 17'd0 : 17'd1);
        write_reg(CFG_BOOST_SECONDS, extreme ? 17'($urandom_range(0, 1) ? 2047 : 0)
                                             : 17'($urandom_range(30, 1800)));
        write_reg(CFG_SEV_FLOOR, 17'($urandom_range(0, 7)));
        write_reg(CFG_ADMIT_BUDGET, extreme ? budgets[$urandom_range(0, 4)]
                                            : 17'($urandom_range(1, 40)));
        write_reg(CFG_SCRIPT_BUDGET, extreme ? budgets[$urandom_range(0, 4)]
                                             : 17'($urandom_range(0, 10)));
        write_reg(CFG_KEEP_ALL_NET, 17'($urandom_range(0, 1)));
        write_reg(CFG_KEEP_LIFECYCLE, 17'($urandom_range(0, 1)));
        write_reg(CFG_KEEP_AUTH, 17'($urandom_range(0, 1)));
        i_cfg_wr_en <= 1'b0;
        for (int n = 0; n < n_words; n++) begin
            if (n == n_words / 2) begin
                drain();
                calm = ($urandom_range(0, 2) == 0);
            end
            send_random_word();
        end
        calm = 1'b0;
        drain();
    endtask

    initial begin
        failed = 1'b0;
        calm = 1'b0;
        stall_left = 0;
        clock_ms = 48'd1000;
        cfg_sh = '{enabled: 1'b1, boost_seconds: 11'd180, sev_floor: 3'd3,
                   admit_budget: 17'd1200, script_budget: 17'd240,
                   keep_all_net: 1'b0, keep_lifecycle: 1'b0, keep_auth: 1'b0};
        for (int k = 0; k < N_IDS; k++) begin
            boosted_ids[k] = '0;
            boosted_dl[k] = '0;
        end
        for (int k = 0; k < 160; k++) id_pool[k] = (k < 100) ? 32'(k + 1) : $urandom;
        id_pool[159] = 32'hFFFF_FFFF;
        slot_ptr = 0;
        boost_until = '0;
        peak_level = '0;
        raise_total = '0;
        win_start = '0;
        win_used = '0;
        script_used = '0;
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_out_stall <= 1'b0;
        i_func <= 1'b0;
        i_now_ms <= '0;
        i_severity <= '0;
        i_proc_id <= '0;
        i_parent_id <= '0;
        i_event_class <= '0;
        i_name_interesting <= 1'b0;
        i_remote_port <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        for (int p = 0; p < 7; p++) test_config_phase(146, p % 2);
        repeat (50) @(posedge i_clk);
        if (!failed && pending_verdicts.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/eabf_pkg.sv
sv/eabf_tbl.sv
sv/eabf_seq.sv
sv/event_admission_boost_filter_unit.sv
verif/event_admission_boost_filter_unit_tb.sv
